>>> rtl/core/dar_pkg.sv
package dar_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 6;
    localparam int unsigned NDAY_W  = 5;
    localparam int unsigned RET_W   = 16;
    localparam int unsigned AGE_W   = 24;
    localparam int unsigned DN_W    = 23;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [YEAR_W-1:0] MIN_YEAR = 14'd1970;

    // Division by 100 of a 14-bit value: multiply by ceil(2^24 / 100) and keep the top bits.
    localparam int unsigned DIV100_SHIFT = 24;
    localparam logic [17:0] DIV100_MUL   = 18'd167773;
    localparam int unsigned QUOT_W       = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOW_YEAR       = 3'd0,
        CFG_NOW_MONTH      = 3'd1,
        CFG_NOW_DAY        = 3'd2,
        CFG_RETENTION_DAYS = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  target_year;
        logic [MONTH_W-1:0] target_month;
        logic [DAY_W-1:0]   target_day;
    } in_t;

    typedef struct packed {
        logic                    date_valid;
        logic signed [AGE_W-1:0] age_days;
        logic                    keep;
    } out_t;

    // Length of a month in a common year; codes outside 1 to 12 give zero.
    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a common year.
    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] ms;
        case (m)
            4'd2:    ms = 9'd31;
            4'd3:    ms = 9'd59;
            4'd4:    ms = 9'd90;
            4'd5:    ms = 9'd120;
            4'd6:    ms = 9'd151;
            4'd7:    ms = 9'd181;
            4'd8:    ms = 9'd212;
            4'd9:    ms = 9'd243;
            4'd10:   ms = 9'd273;
            4'd11:   ms = 9'd304;
            4'd12:   ms = 9'd334;
            default: ms = 9'd0;
        endcase
        return ms;
    endfunction

endpackage

>>> rtl/core/dar_day_count.sv
module dar_day_count
    import dar_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    output logic [DN_W-1:0]    day_count,
    output logic               date_ok
);

    // Stage 1: quotients by 100 of the year and of the year before it.
    logic [YEAR_W-1:0]  y1_reg, y1_next;
    logic [YEAR_W-1:0]  p1_reg, p1_next;
    logic [MONTH_W-1:0] m1_reg;
    logic [DAY_W-1:0]   d1_reg;
    logic [QUOT_W-1:0]  qy1_reg, qy1_next;
    logic [QUOT_W-1:0]  qp1_reg, qp1_next;
    logic               yok1_reg, yok1_next;
    logic [31:0]        prod_y, prod_p;

    always_comb
    begin
        y1_next   = year;
        p1_next   = year - YEAR_W'(1);
        prod_y    = 32'(year) * 32'(DIV100_MUL);
        prod_p    = 32'(p1_next) * 32'(DIV100_MUL);
        qy1_next  = prod_y[DIV100_SHIFT +: QUOT_W];
        qp1_next  = prod_p[DIV100_SHIFT +: QUOT_W];
        yok1_next = (year >= MIN_YEAR);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg   <= y1_next;
            p1_reg   <= p1_next;
            m1_reg   <= month;
            d1_reg   <= day;
            qy1_reg  <= qy1_next;
            qp1_reg  <= qp1_next;
            yok1_reg <= yok1_next;
        end
    end

    // Stage 2: leap year, date check and the 365-day and four-year parts of the count.
    logic              leap;
    logic [5:0]        len;
    logic [14:0]       hundreds;
    logic [DN_W-1:0]   t2_reg, t2_next;
    logic [QUOT_W-1:0] qp2_reg;
    logic [8:0]        ms2_reg, ms2_next;
    logic              adj2_reg, adj2_next;
    logic [DAY_W-1:0]  d2_reg;
    logic              ok2_reg, ok2_next;

    always_comb
    begin
        hundreds  = 15'(qy1_reg) * 15'd100;
        leap      = (y1_reg[1:0] == 2'b00) &&
                    ((15'(y1_reg) != hundreds) || (qy1_reg[1:0] == 2'b00));
        len       = 6'(month_len(m1_reg)) + 6'((m1_reg == 4'd2) && leap);
        ok2_next  = yok1_reg && (m1_reg >= 4'd1) && (m1_reg <= 4'd12) &&
                    (d1_reg != '0) && (d1_reg <= len);
        t2_next   = DN_W'(32'(p1_reg) * 32'd365) + DN_W'(p1_reg >> 2);
        ms2_next  = month_start(m1_reg);
        adj2_next = (m1_reg > 4'd2) && leap;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t2_reg   <= t2_next;
            qp2_reg  <= qp1_reg;
            ms2_reg  <= ms2_next;
            adj2_reg <= adj2_next;
            d2_reg   <= d1_reg;
            ok2_reg  <= ok2_next;
        end
    end

    // Stage 3: century corrections, month offset and day of month.
    logic [DN_W-1:0] dn3_reg, dn3_next;
    logic            ok3_reg;

    always_comb
    begin
        dn3_next = t2_reg - DN_W'(qp2_reg) + DN_W'(qp2_reg >> 2) + DN_W'(ms2_reg) +
                   DN_W'(adj2_reg) + DN_W'(d2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dn3_reg <= dn3_next;
            ok3_reg <= ok2_reg;
        end
    end

    assign day_count = dn3_reg;
    assign date_ok   = ok3_reg;

endmodule

>>> rtl/core/date_age_retention_check.sv
// Record retention check by date age. Each input transaction carries one
// record date; the block checks it and the configured current date against
// Gregorian rules (year 1970 or later, month 1 to 12, day within the month,
// leap Februaries included), turns both into day counts and returns the
// signed age in days (current minus record) with a keep flag that is set when
// the dates are valid and the age does not exceed retention_days. Records
// dated in the future have a negative age and are kept. When either date is
// invalid, date_valid, age_days and keep are all zero. The block takes one
// transaction per clock while no result waits on a stalled output:
// three stages compute the two day counts side by side, the fourth takes the
// difference and the retention compare. A stall on the output freezes all
// four stages together, so in_stall follows out_stall while a result waits.
// Configuration writes are always ready; indexes beyond the four registers
// are ignored, and writes must only happen while no transaction is in flight.
module date_age_retention_check
    import dar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers.
    logic [YEAR_W-1:0]  now_year_reg;
    logic [MONTH_W-1:0] now_month_reg;
    logic [NDAY_W-1:0]  now_day_reg;
    logic [RET_W-1:0]   retention_days_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_year_reg       <= MIN_YEAR;
            now_month_reg      <= 4'd1;
            now_day_reg        <= 5'd1;
            retention_days_reg <= 16'd30;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_NOW_YEAR:       now_year_reg       <= cfg_data[YEAR_W-1:0];
                CFG_NOW_MONTH:      now_month_reg      <= cfg_data[MONTH_W-1:0];
                CFG_NOW_DAY:        now_day_reg        <= cfg_data[NDAY_W-1:0];
                CFG_RETENTION_DAYS: retention_days_reg <= cfg_data[RET_W-1:0];
                default:            ;
            endcase
        end
    end

    // The whole pipeline advances together unless a finished result is held.
    logic advance;
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // Valid bits that travel alongside the three day-count stages.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // The record date and the current date run through identical units, so
    // the current date is sampled together with each record.
    logic [DN_W-1:0] tar_count, now_count;
    logic            tar_ok, now_ok;

    dar_day_count u_tar_count (
        .clk       (clk),
        .en        (advance),
        .year      (in_data.target_year),
        .month     (in_data.target_month),
        .day       (in_data.target_day),
        .day_count (tar_count),
        .date_ok   (tar_ok)
    );

    dar_day_count u_now_count (
        .clk       (clk),
        .en        (advance),
        .year      (now_year_reg),
        .month     (now_month_reg),
        .day       (DAY_W'(now_day_reg)),
        .day_count (now_count),
        .date_ok   (now_ok)
    );

    // Final stage: age, retention compare and the output register.
    logic                    out_valid_reg;
    out_t                    out_reg, out_next;
    logic                    both_ok;
    logic signed [AGE_W-1:0] age;

    always_comb
    begin
        both_ok             = tar_ok && now_ok;
        age                 = $signed(AGE_W'(now_count) - AGE_W'(tar_count));
        out_next.date_valid = both_ok;
        out_next.age_days   = both_ok ? age : '0;
        out_next.keep       = both_ok &&
                              (age[AGE_W-1] || (age <= $signed(AGE_W'(retention_days_reg))));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // An invalid result carries no age and is never kept.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.date_valid |-> out_data.age_days == '0 && !out_data.keep)
        else $error("invalid date result carries nonzero age or keep");

    // A record dated after the current date is always kept.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.date_valid && out_data.age_days[AGE_W-1] |-> out_data.keep)
        else $error("future record not kept");

    // An accepted transaction occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted transaction lost at stage 1");

    // While the output is held, no stage may move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s3_valid_reg) && $stable(s2_valid_reg) && out_valid)
        else $error("pipeline moved during a stall");

endmodule

>>> dv/tb_date_age_retention_check.sv
`timescale 1ns / 1ps

module tb_date_age_retention_check;
    import dar_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 3;
    // The limit stays well above the slowest correct run, even with every
    // item waiting out the longest sender gap and the longest receiver stall.
    localparam int MAX_CYCLES       = 400000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES     = 16;
    localparam int EXTREME_ITEMS    = 35;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 100;
    localparam int IN_BITS          = $bits(in_t);

    // Keeps its own copy of the reference date and the retention limit, works
    // out the verdict for every record the block accepts, and compares each
    // verdict the block returns against the oldest one still owed.
    class retention_ledger;
        logic [YEAR_W-1:0]  cur_year;
        logic [MONTH_W-1:0] cur_month;
        logic [NDAY_W-1:0]  cur_day;
        logic [RET_W-1:0]   keep_limit;
        out_t               verdicts_due[$];
        int                 mismatches;

        function new();
            cur_year   = MIN_YEAR;
            cur_month  = MONTH_W'(1);
            cur_day    = NDAY_W'(1);
            keep_limit = RET_W'(30);
            mismatches = 0;
        endfunction

        function bit leap_year(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_days(int y, int m);
            case (m)
                2:           return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function bit calendar_ok(int y, int m, int d);
            if (y < int'(MIN_YEAR) || m < 1 || m > 12 || d < 1)
                return 1'b0;
            return d <= month_days(y, m);
        endfunction

        // Days since the start of year 1: whole years, then whole months of
        // the given year, then the day itself.
        function int day_count(int y, int m, int d);
            int p;
            int n;
            p = y - 1;
            n = 365 * p + p / 4 - p / 100 + p / 400;
            for (int k = 1; k < m; k++)
                n += month_days(y, k);
            return n + d;
        endfunction

        function out_t predict_verdict(in_t rec);
            out_t v;
            int   age;
            v = '0;
            if (!calendar_ok(rec.target_year, rec.target_month, rec.target_day) ||
                !calendar_ok(cur_year, cur_month, cur_day))
                return v;
            age = day_count(cur_year, cur_month, cur_day) -
                  day_count(rec.target_year, rec.target_month, rec.target_day);
            v.date_valid = 1'b1;
            v.age_days   = AGE_W'(age);
            v.keep       = age <= int'(keep_limit);
            return v;
        endfunction

        function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_NOW_YEAR:       cur_year   = data[YEAR_W-1:0];
                CFG_NOW_MONTH:      cur_month  = data[MONTH_W-1:0];
                CFG_NOW_DAY:        cur_day    = data[NDAY_W-1:0];
                CFG_RETENTION_DAYS: keep_limit = data[RET_W-1:0];
                default:            ;
            endcase
        endfunction

        function void note_record(in_t rec);
            verdicts_due.push_back(predict_verdict(rec));
        endfunction

        function void check_verdict(out_t got);
            out_t want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: result with no record pending: expected none, got %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.date_valid !== want.date_valid) begin
                $display("%0t: date_valid mismatch: expected %0b, got %0b",
                         $time, want.date_valid, got.date_valid);
                mismatches++;
            end
            if (got.age_days !== want.age_days) begin
                $display("%0t: age_days mismatch: expected %0d, got %0d",
                         $time, want.age_days, got.age_days);
                mismatches++;
            end
            if (got.keep !== want.keep) begin
                $display("%0t: keep mismatch: expected %0b, got %0b",
                         $time, want.keep, got.keep);
                mismatches++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    retention_ledger ledger;
    // When set, neither side inserts gaps or stalls.
    bit              no_idle;
    // Asks the receiver for one long stall; the receiver clears it when done.
    bit              hold_output;
    int              cycle_count;

    date_age_retention_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // All three channels are observed at the rising edge, where the block
    // itself decides what moves. Stimulus only changes at the falling edge,
    // so the values seen here are the ones the block acts on.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                ledger.apply_write(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                ledger.note_record(in_data);
            if (out_valid && !out_stall)
                ledger.check_verdict(out_data);
        end
    end

    // Idle length for either side: mostly none, often a few cycles, now and
    // then a long one.
    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(32, 4);
    endfunction

    // Receiver: alternates stall-free runs with stalls of random length. On
    // request it holds off for a long stretch so the pipeline fills and the
    // block pushes back on its input.
    initial begin : receiver
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_output) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_output = 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    stall_left = idle_gap();
                    run_left   = $urandom_range(24, 0);
                end
            end
        end
    end

    // Offers one record and returns once the block has taken it. The valid
    // stays high across back-to-back transactions; it is only lowered for a
    // gap or for a pause that waits until every verdict has come back.
    task automatic send_item(input in_t rec, input int gap, input bit drain);
        @(negedge clk);
        if (gap > 0 || drain) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            if (drain) begin
                while (ledger.pending() != 0) @(posedge clk);
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= rec;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_date(input int y, input int m, input int d);
        in_t rec;
        rec.target_year  = YEAR_W'(y);
        rec.target_month = MONTH_W'(m);
        rec.target_day   = DAY_W'(d);
        send_item(rec, idle_gap(), 1'b0);
    endtask

    task automatic finish_phase();
        @(negedge clk);
        in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
    endtask

    // One register write. Bits above the register's width carry junk, which
    // the block must drop. The valid is left high so writes can follow back
    // to back; the caller lowers it after the last one.
    task automatic post_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                              input int width);
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] junk;
        mask = CFG_DATA_W'((longint'(1) << width) - 1);
        junk = CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (CFG_DATA_W'(value) & mask) | (junk & ~mask);
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Loads a new reference date and retention limit. Only called with no
    // transaction in flight.
    task automatic set_reference(input int y, input int m, input int d, input int limit);
        while (ledger.pending() != 0) @(posedge clk);
        post_write(CFG_NOW_YEAR, y, YEAR_W);
        post_write(CFG_NOW_MONTH, m, MONTH_W);
        post_write(CFG_NOW_DAY, d, NDAY_W);
        post_write(CFG_RETENTION_DAYS, limit, RET_W);
        // An index past the last register must leave every setting alone.
        post_write(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1,
                                             int'(CFG_RETENTION_DAYS) + 1)),
                   $urandom, 0);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly a valid reference date in recent years; sometimes any year, and
    // sometimes a random month and day; when broken, every verdict is invalid.
    task automatic random_reference();
        int y;
        int m;
        int d;
        int limit;
        y = ($urandom_range(9, 0) < 7) ? $urandom_range(2100, MIN_YEAR)
                                        : $urandom_range(16383, MIN_YEAR);
        if ($urandom_range(9, 0) == 0) begin
            m = $urandom_range(15, 0);
            d = $urandom_range(31, 0);
        end else begin
            m = $urandom_range(12, 1);
            d = $urandom_range(ledger.month_days(y, m), 1);
        end
        limit = $urandom_range(1, 0) ? $urandom_range(800, 0) : $urandom_range(65535, 0);
        set_reference(y, m, d, limit);
    endtask

    // Random record. Most are valid dates within a few years of the reference
    // date, so ages land on both sides of the retention limit and in the
    // future; the rest are valid dates of any year, dates with a random month
    // and day, and raw random bits.
    function automatic in_t random_record();
        in_t rec;
        int  pick;
        int  y;
        int  lo;
        int  hi;
        pick = $urandom_range(9, 0);
        if (pick == 0) begin
            rec = in_t'(IN_BITS'($urandom));
            return rec;
        end
        if (pick == 1) begin
            y = $urandom_range(16383, MIN_YEAR);
        end else begin
            lo = int'(ledger.cur_year) - 3;
            hi = int'(ledger.cur_year) + 1;
            if (lo < int'(MIN_YEAR))
                lo = MIN_YEAR;
            if (hi > 16383)
                hi = 16383;
            if (hi < lo)
                hi = lo;
            y = $urandom_range(hi, lo);
        end
        rec.target_year = YEAR_W'(y);
        if (pick == 9) begin
            rec.target_month = MONTH_W'($urandom_range(15, 0));
            rec.target_day   = DAY_W'($urandom_range(63, 0));
        end else begin
            rec.target_month = MONTH_W'($urandom_range(12, 1));
            rec.target_day   = DAY_W'($urandom_range(ledger.month_days(y, rec.target_month), 1));
        end
        return rec;
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_item(random_record(), idle_gap(), 1'b0);
        finish_phase();
    endtask

    initial begin
        ledger      = new();
        cycle_count = 0;
        no_idle     = 1'b0;
        hold_output = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The reset reference date is the first day of the earliest valid
        // year, with a 30 day limit.
        send_date(1970, 1, 1);
        send_date(1970, 1, 31);
        send_date(1969, 12, 1);
        finish_phase();

        // Directed records against a reference date just after a leap day.
        set_reference(2024, 3, 1, 366);
        send_date(0, 0, 0);
        send_date(16383, 15, 63);
        send_date(1969, 12, 31);
        send_date(1970, 1, 1);
        send_date(2024, 13, 1);
        send_date(2024, 0, 10);
        send_date(2024, 1, 0);
        send_date(2024, 1, 32);
        send_date(2024, 1, 31);
        send_date(2024, 2, 29);
        // A century year is a leap year only when divisible by 400.
        send_date(2023, 2, 29);
        send_date(2100, 2, 29);
        send_date(2000, 2, 29);
        send_date(2024, 2, 30);
        send_date(2024, 4, 31);
        // A record in the future has a negative age and is always kept.
        send_date(2024, 4, 30);
        // Exactly at the retention limit, then one day past it.
        send_date(2023, 3, 1);
        send_date(2023, 2, 28);
        send_date(2024, 3, 1);
        send_date(16383, 12, 31);
        send_date(1970, 12, 31);
        finish_phase();

        // Extreme settings: the latest reference date with the widest limit,
        // the earliest one with a zero limit, and two broken reference dates.
        set_reference(16383, 12, 31, 65535);
        random_phase(EXTREME_ITEMS);
        set_reference(MIN_YEAR, 1, 1, 0);
        random_phase(EXTREME_ITEMS);
        set_reference(1969, 6, 15, 100);
        random_phase(EXTREME_ITEMS);
        set_reference(2023, 2, 29, 100);
        random_phase(EXTREME_ITEMS);

        // Random settings. One phase starts with a long receiver hold while
        // records keep coming, one pauses halfway until every verdict is back,
        // and one runs without any idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_reference();
            if (ph == 1)
                hold_output = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                no_idle = (ph == 3) || (ph == 1 && i < 40);
                send_item(random_record(), idle_gap(), ph == 2 && i == PHASE_ITEMS / 2);
            end
            no_idle = 1'b0;
            finish_phase();
        end

        // Leave time for any stray result to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
